FILE: rtl/core/gbsd_pkg.sv
`timescale 1ns / 1ps
package gbsd_pkg;

  // fixed field widths
  localparam int RawW   = 16;
  localparam int RateW  = 25;
  localparam int ConvW  = 16;
  localparam int ThrW   = 24;
  localparam int CalibW = 11;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int NumAxes  = 3;

  // default for the largest calibration run
  localparam int MaxCalibSamplesDef = 1024;

  // register reset values
  localparam logic [CalibW-1:0] CalibSamplesRst   = CalibW'(64);
  localparam logic [ConvW-1:0]  ConversionRateRst = ConvW'(573);
  localparam logic [ThrW-1:0]   ShakeThresholdRst = ThrW'(2560);

  // bias after reset, per axis x, y, z
  localparam logic signed [RawW-1:0] BiasRst [NumAxes] = '{
    16'sd300, -16'sd1600, 16'sd100
  };

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCalibSamples   = 2'd0,
    CfgConversionRate = 2'd1,
    CfgShakeThreshold = 2'd2
  } cfg_reg_e;

  // command codes carried in tuser
  typedef enum logic {
    CmdSample = 1'b0,
    CmdStart  = 1'b1
  } cmd_e;

  // per-cycle control from the top level to every lane
  typedef struct packed {
    logic start;      // start command accepted: clear bias and accumulator
    logic cal;        // calibration sample accepted: accumulate
    logic norm;       // normal sample accepted: load product stage
    logic div_start;  // kick off the bias division
    logic upd;        // product stage moves to output: update previous rate
  } gbsd_ctrl_t;

endpackage

FILE: rtl/core/gbsd_div.sv
`timescale 1ns / 1ps
// signed by unsigned restoring divider, one quotient bit a cycle,
// truncates toward zero
module gbsd_div #(
  parameter int DividendW = 27,
  parameter int DivisorW  = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DividendW-1:0] dividend_i,
  input  logic        [DivisorW-1:0]  divisor_i,
  output logic                        done_o,
  output logic signed [15:0]          quot_o
);
  import gbsd_pkg::*;

  localparam int StepW = (DividendW > 1) ? $clog2(DividendW) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(DividendW - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic                 neg_q, neg_d;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    trial_sub;
  logic                 fits;
  logic [DividendW-1:0] quo_signed;

  // one restoring step
  assign trial     = {rem_q, quo_q[DividendW-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign fits      = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
      neg_d  = dividend_i[DividendW-1];
      quo_d  = dividend_i[DividendW-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? trial_sub[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d  = {quo_q[DividendW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // restore the sign; the mean of 16-bit counts fits 16 bits
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o     = quo_signed[15:0];
  assign done_o     = done_q;

endmodule

FILE: rtl/core/gbsd_lane.sv
`timescale 1ns / 1ps
// one axis: accumulator, bias, scaling multiply and rate change test
module gbsd_lane #(
  parameter int LaneIdx         = 0,
  parameter int MaxCalibSamples = gbsd_pkg::MaxCalibSamplesDef,
  parameter int CntW            = $clog2(MaxCalibSamples + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbsd_pkg::gbsd_ctrl_t                ctrl_i,
  input  logic signed [gbsd_pkg::RawW-1:0]    raw_i,
  input  logic        [gbsd_pkg::ConvW-1:0]   conv_i,
  input  logic        [gbsd_pkg::ThrW-1:0]    thr_i,
  input  logic        [CntW-1:0]              divisor_i,
  output logic signed [gbsd_pkg::RateW-1:0]   rate_o,
  output logic                                shake_o,
  output logic                                div_done_o
);
  import gbsd_pkg::*;

  localparam int AccW  = CntW + RawW;
  localparam int DiffW = RawW + 1;
  localparam int ProdW = 2 * DiffW;

  logic signed [RawW-1:0]  bias_q, bias_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [RateW-1:0] prev_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_d;
  logic signed [RateW:0]   delta;
  logic        [RateW:0]   delta_abs;
  logic signed [15:0]      quot;

  // bias division at the end of calibration
  gbsd_div #(
    .DividendW(AccW),
    .DivisorW (CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl_i.div_start),
    .dividend_i(acc_q),
    .divisor_i (divisor_i),
    .done_o    (div_done_o),
    .quot_o    (quot)
  );

  // bias and accumulator
  always_comb begin
    bias_d = bias_q;
    acc_d  = acc_q;
    if (ctrl_i.start) begin
      bias_d = '0;
      acc_d  = '0;
    end else if (ctrl_i.cal) begin
      acc_d = acc_q + {{(AccW-RawW){raw_i[RawW-1]}}, raw_i};
    end else if (div_done_o) begin
      bias_d = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= BiasRst[LaneIdx];
      acc_q  <= '0;
      prev_q <= '0;
    end else begin
      bias_q <= bias_d;
      acc_q  <= acc_d;
      if (ctrl_i.upd) begin
        prev_q <= rate_o;
      end
    end
  end

  // product stage
  assign diff   = {raw_i[RawW-1], raw_i} - {bias_q[RawW-1], bias_q};
  assign prod_d = diff * $signed({1'b0, conv_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.norm) begin
      prod_q <= prod_d;
    end
  end

  // floor shift by 8, then compare the change against the threshold
  assign rate_o    = prod_q[RateW+7:8];
  assign delta     = {rate_o[RateW-1], rate_o} - {prev_q[RateW-1], prev_q};
  assign delta_abs = delta[RateW] ? (~delta + 1'b1) : delta;
  assign shake_o   = (delta_abs > {{(RateW+1-ThrW){1'b0}}, thr_i});

endmodule

FILE: rtl/core/gyro_bias_scale_shake_detect_core.sv
`timescale 1ns / 1ps
// an accepted input word passes the product stage register, then the output register
// throughput: one word per cycle while the output is ready, set by the product
// stage and output register; the calibration sample that ends a run stalls
// input while the bias divider runs
// reset: asynchronous active low; registers go to 64, 573, 2560, bias to
// 300, -1600, 100, accumulators and previous rates to zero, not calibrating
module gyro_bias_scale_shake_detect_core #(
  parameter int MaxCalibSamples = gbsd_pkg::MaxCalibSamplesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbsd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gbsd_pkg::CfgDataW-1:0]     cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high
  input  logic [47:0]                       s_axis_tdata,
  // command
  input  logic [0:0]                        s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rate_x, rate_y, rate_z, zero padding
  output logic [79:0]                       m_axis_tdata,
  // shake, rate_valid
  output logic [1:0]                        m_axis_tuser
);
  import gbsd_pkg::*;

  localparam int CntW = $clog2(MaxCalibSamples + 1);
  localparam int CmpW = (CntW > CalibW) ? CntW : CalibW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MaxCalibSamples);

  logic [CalibW-1:0] calib_samples_q;
  logic [ConvW-1:0]  conversion_rate_q;
  logic [ThrW-1:0]   shake_threshold_q;

  logic              calibrating_q;
  logic              dividing_q;
  logic              div_start_q;
  logic [CntW-1:0]   samples_taken_q;
  logic              s1_valid_q;
  logic              s1_norm_q;
  logic              out_valid_q;
  logic [NumAxes*RateW-1:0] out_rates_q;
  logic              out_shake_q;
  logic              out_rate_valid_q;

  logic              accept;
  logic              is_start;
  logic              s1_adv;
  logic              s1_move;
  logic [CntW-1:0]   cnt_next;
  logic [CmpW-1:0]   calib_ext;
  logic [CmpW-1:0]   n_eff;
  logic              cal_last;
  gbsd_ctrl_t        ctrl;

  logic signed [RawW-1:0]  raw     [NumAxes];
  logic signed [RateW-1:0] rate    [NumAxes];
  logic [NumAxes-1:0]      shake;
  logic [NumAxes-1:0]      div_done;

  // config writes are taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_samples_q   <= CalibSamplesRst;
      conversion_rate_q <= ConversionRateRst;
      shake_threshold_q <= ShakeThresholdRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgCalibSamples:   calib_samples_q   <= cfg_data_i[CalibW-1:0];
        CfgConversionRate: conversion_rate_q <= cfg_data_i[ConvW-1:0];
        CfgShakeThreshold: shake_threshold_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // raw counts per axis
  assign raw[0] = s_axis_tdata[15:0];
  assign raw[1] = s_axis_tdata[31:16];
  assign raw[2] = s_axis_tdata[47:32];

  // handshake and word kind
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && s1_adv;
  assign s_axis_tready = !dividing_q && !div_start_q && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_start      = (cmd_e'(s_axis_tuser[0]) == CmdStart);

  // effective sample count, limited to 1 .. max
  assign calib_ext = CmpW'(calib_samples_q);
  assign cnt_next  = samples_taken_q + 1'b1;
  always_comb begin
    n_eff = calib_ext;
    if (calib_ext == '0) begin
      n_eff = CmpW'(1);
    end else if (calib_ext > MaxCmp) begin
      n_eff = MaxCmp;
    end
  end
  assign cal_last = (CmpW'(cnt_next) >= n_eff);

  always_comb begin
    ctrl.start     = accept && is_start;
    ctrl.cal       = accept && !is_start && calibrating_q;
    ctrl.norm      = accept && !is_start && !calibrating_q;
    ctrl.div_start = div_start_q;
    ctrl.upd       = s1_move && s1_norm_q;
  end

  // calibration sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrating_q   <= 1'b0;
      dividing_q      <= 1'b0;
      div_start_q     <= 1'b0;
      samples_taken_q <= '0;
    end else begin
      div_start_q <= ctrl.cal && cal_last;
      if (ctrl.start) begin
        calibrating_q   <= 1'b1;
        samples_taken_q <= '0;
      end else if (ctrl.cal) begin
        samples_taken_q <= cnt_next;
        if (cal_last) begin
          calibrating_q <= 1'b0;
          dividing_q    <= 1'b1;
        end
      end
      if (&div_done) begin
        dividing_q <= 1'b0;
      end
    end
  end

  // axis lanes
  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    gbsd_lane #(
      .LaneIdx        (g),
      .MaxCalibSamples(MaxCalibSamples),
      .CntW           (CntW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .raw_i     (raw[g]),
      .conv_i    (conversion_rate_q),
      .thr_i     (shake_threshold_q),
      .divisor_i (samples_taken_q),
      .rate_o    (rate[g]),
      .shake_o   (shake[g]),
      .div_done_o(div_done[g])
    );
  end

  // product stage valid and kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_norm_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_norm_q  <= ctrl.norm;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      if (s1_norm_q) begin
        out_rates_q      <= {rate[2], rate[1], rate[0]};
        out_shake_q      <= |shake;
        out_rate_valid_q <= 1'b1;
      end else begin
        out_rates_q      <= '0;
        out_shake_q      <= 1'b0;
        out_rate_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(80 - NumAxes*RateW){1'b0}}, out_rates_q};
  assign m_axis_tuser  = {out_rate_valid_q, out_shake_q};

`ifndef SYNTH
  // no input is taken while the bias divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dividing_q |-> !s_axis_tready)
    else $error("input accepted during bias division");

  // the three lane dividers finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done == '0) || (div_done == '1))
    else $error("lane dividers out of step");

  // the last calibration sample starts the division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cal && cal_last) |=> (dividing_q && div_start_q && !calibrating_q))
    else $error("division not started at end of calibration");
`endif

endmodule
